@@ hw/rtl/lodc_pkg.sv @@
`default_nettype none
package lodc_pkg;

  // Sizes
  localparam int LOCK_COUNT  = 32;
  localparam int STACK_DEPTH = 16;
  localparam int LID_W       = (LOCK_COUNT > 1) ? $clog2(LOCK_COUNT) : 1;
  localparam int SP_W        = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);

  // Port field widths
  localparam int ID_IN_W  = 5;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;

  // Item kinds
  localparam logic KIND_ACQUIRE = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_DEADLOCK  = 3'd1,
    ST_NONE_HELD = 3'd2,
    ST_NOT_TOP   = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_EMIT
  } state_t;

  typedef logic [LOCK_COUNT-1:0] lock_vec_t;

  // Edge write into one row cell
  typedef struct packed {
    logic             en;
    logic [LID_W-1:0] col;
  } edge_wr_t;

  // Held stack command
  typedef struct packed {
    logic             push;
    logic             pop;
    logic [LID_W-1:0] id;
  } stk_cmd_t;

  // Map the raw lock number onto the lock range
  function automatic logic [LID_W-1:0] lock_reduce(input logic [ID_IN_W-1:0] raw);
    logic [LID_W-1:0] r;
    r = '0;
    for (int i = 0; i < (1 << ID_IN_W); i++) begin
      if (raw == ID_IN_W'(i)) r = LID_W'(i % LOCK_COUNT);
    end
    return r;
  endfunction

  // Fit an internal lock number to the port width
  function automatic logic [ID_IN_W-1:0] lock_to_port(input logic [LID_W-1:0] lid);
    logic [LID_W+ID_IN_W-1:0] w;
    w = {{ID_IN_W{1'b0}}, lid};
    return w[ID_IN_W-1:0];
  endfunction

  // Mask the stack depth to the count field
  function automatic logic [COUNT_W-1:0] depth_to_count(input logic [DEPTH_W-1:0] d);
    logic [DEPTH_W+COUNT_W-1:0] w;
    w = {{COUNT_W{1'b0}}, d};
    return w[COUNT_W-1:0];
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/lodc_if.sv @@
`default_nettype none
interface lodc_in_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [lodc_pkg::ID_IN_W-1:0]  lock_id;

  modport source (output valid, kind, lock_id, input ready);
  modport sink   (input valid, kind, lock_id, output ready);
endinterface

interface lodc_out_if;
  logic                          valid;
  logic                          ready;
  lodc_pkg::status_t             status;
  logic [lodc_pkg::ID_IN_W-1:0]  earlier_lock;
  logic [lodc_pkg::COUNT_W-1:0]  held_count;

  modport source (output valid, status, earlier_lock, held_count, input ready);
  modport sink   (input valid, status, earlier_lock, held_count, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/lodc_edge_cell.sv @@
`default_nettype none
module lodc_edge_cell (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire lodc_pkg::edge_wr_t  wr,
  input  wire logic                seen,
  input  wire lodc_pkg::lock_vec_t reach_in,
  output lodc_pkg::lock_vec_t      reach_out,
  output lodc_pkg::lock_vec_t      row
);

  lodc_pkg::lock_vec_t row_r;

  // Hold one row of the order graph: bit n set means this lock precedes lock n
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
    end else if (wr.en) begin
      row_r[wr.col] <= 1'b1;
    end
  end

  // Add this row's successors to the wavefront when this lock is reached
  assign reach_out = reach_in | (seen ? row_r : '0);
  assign row       = row_r;

endmodule
`default_nettype wire

@@ hw/rtl/lodc_held_stack.sv @@
`default_nettype none
module lodc_held_stack (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire lodc_pkg::stk_cmd_t           cmd,
  output logic [lodc_pkg::DEPTH_W-1:0]      depth,
  output logic [lodc_pkg::LID_W-1:0]        top
);

  logic [lodc_pkg::LID_W-1:0]   mem_r [lodc_pkg::STACK_DEPTH];
  logic [lodc_pkg::DEPTH_W-1:0] depth_r;
  logic [lodc_pkg::LID_W-1:0]   top_r;
  logic [lodc_pkg::DEPTH_W-1:0] below_idx;

  // Track the fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
    end else if (cmd.push) begin
      depth_r <= depth_r + 1'b1;
    end else if (cmd.pop) begin
      depth_r <= depth_r - 1'b1;
    end
  end

  // Slot just under the current top
  assign below_idx = depth_r - lodc_pkg::DEPTH_W'(2);

  // Write the pushed lock at the free slot; keep the top entry in a register
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem_r[depth_r[lodc_pkg::SP_W-1:0]] <= cmd.id;
      top_r                              <= cmd.id;
    end else if (cmd.pop && (depth_r > lodc_pkg::DEPTH_W'(1))) begin
      top_r <= mem_r[below_idx[lodc_pkg::SP_W-1:0]];
    end
  end

  assign top   = top_r;
  assign depth = depth_r;

endmodule
`default_nettype wire

@@ hw/rtl/lock_order_deadlock_checker_core.sv @@
`default_nettype none
// Lock-order deadlock checker. Each input transfer is an acquire or a release
// of a lock number; each produces exactly one result transfer carrying a
// status, the lock that was on top of the held stack before an acquire (zero
// on releases), and the number of locks held afterwards. The order graph
// lives in a row of LOCK_COUNT cells, one per lock, cleared by reset; the
// held stack is STACK_DEPTH entries deep. Each item is decided and its
// transfer taken in the idle state, then its result is loaded into the
// output register in the emit state, which waits while the previous result
// is still unaccepted; the next item is taken only after that load. An
// acquire that would record a new order edge first walks the graph in a
// search state, one hop per cycle through the OR chain across the cells,
// stopping as soon as the earlier lock is reached or the set stops growing.
// One item is in flight at a time; a new item is taken while the previous
// result still waits, and it holds until the output register frees.
module lock_order_deadlock_checker_core (
  input  wire logic    clk,
  input  wire logic    rst_n,
  lodc_in_if.sink      in_chan,
  lodc_out_if.source   out_chan
);

  localparam int LC = lodc_pkg::LOCK_COUNT;

  lodc_pkg::state_t             state_r, state_nxt;
  lodc_pkg::status_t            status_r, status_nxt;
  logic [lodc_pkg::LID_W-1:0]   id_r, id_nxt;
  logic [lodc_pkg::LID_W-1:0]   earlier_r, earlier_nxt;
  lodc_pkg::lock_vec_t          seen_r, seen_nxt;

  logic                         out_valid_r;
  lodc_pkg::status_t            out_status_r;
  logic [lodc_pkg::ID_IN_W-1:0] out_earlier_r;
  logic [lodc_pkg::COUNT_W-1:0] out_count_r;

  logic [lodc_pkg::DEPTH_W-1:0] stk_depth;
  logic [lodc_pkg::LID_W-1:0]   stk_top;
  lodc_pkg::stk_cmd_t           stk_cmd;

  lodc_pkg::lock_vec_t          row_w   [LC];
  lodc_pkg::lock_vec_t          chain_w [LC+1];
  lodc_pkg::lock_vec_t          reach_nxt;
  logic                         edge_set;

  logic                         accept;
  logic                         out_load;
  logic [lodc_pkg::LID_W-1:0]   in_id;
  logic                         held_any;
  logic                         full;
  logic                         need_search;
  logic                         search_hit;
  logic                         search_done;
  lodc_pkg::status_t            dec_status;
  logic [lodc_pkg::LID_W-1:0]   dec_earlier;

  // Held stack
  lodc_held_stack u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (stk_cmd),
    .depth (stk_depth),
    .top   (stk_top)
  );

  // Row of graph cells with the reachability chain running through them
  assign chain_w[0] = '0;
  for (genvar g = 0; g < LC; g++) begin : g_cell
    lodc_pkg::edge_wr_t cell_wr;
    assign cell_wr.en  = edge_set && (earlier_r == lodc_pkg::LID_W'(g));
    assign cell_wr.col = id_r;
    lodc_edge_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .wr        (cell_wr),
      .seen      (seen_r[g]),
      .reach_in  (chain_w[g]),
      .reach_out (chain_w[g+1]),
      .row       (row_w[g])
    );
  end

  assign reach_nxt   = seen_r | chain_w[LC];
  assign search_hit  = reach_nxt[earlier_r];
  assign search_done = search_hit || (reach_nxt == seen_r);

  // Decode an arriving item against the stack and the graph
  assign accept   = in_chan.valid && in_chan.ready;
  assign in_id    = lodc_pkg::lock_reduce(in_chan.lock_id);
  assign held_any = (stk_depth != '0);
  assign full     = (stk_depth >= lodc_pkg::DEPTH_W'(lodc_pkg::STACK_DEPTH));

  always_comb begin
    need_search = 1'b0;
    dec_status  = lodc_pkg::ST_OK;
    dec_earlier = '0;
    if (in_chan.kind == lodc_pkg::KIND_ACQUIRE) begin
      dec_earlier = held_any ? stk_top : '0;
      if (full) begin
        dec_status = lodc_pkg::ST_OVERFLOW;
      end else if (held_any && (stk_top != in_id) && !row_w[stk_top][in_id]) begin
        need_search = 1'b1;
      end
    end else begin
      if (!held_any) begin
        dec_status = lodc_pkg::ST_NONE_HELD;
      end else if (stk_top != in_id) begin
        dec_status = lodc_pkg::ST_NOT_TOP;
      end
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lodc_pkg::S_IDLE: begin
        if (accept) state_nxt = need_search ? lodc_pkg::S_SEARCH : lodc_pkg::S_EMIT;
      end
      lodc_pkg::S_SEARCH: begin
        if (search_done) state_nxt = lodc_pkg::S_EMIT;
      end
      lodc_pkg::S_EMIT: begin
        if (out_load) state_nxt = lodc_pkg::S_IDLE;
      end
      default: state_nxt = lodc_pkg::S_IDLE;
    endcase
  end

  // Control outputs and item registers
  always_comb begin
    in_chan.ready = 1'b0;
    out_load      = 1'b0;
    edge_set      = 1'b0;
    stk_cmd       = '0;
    stk_cmd.id    = id_r;
    status_nxt    = status_r;
    id_nxt        = id_r;
    earlier_nxt   = earlier_r;
    seen_nxt      = seen_r;
    unique case (state_r)
      lodc_pkg::S_IDLE: begin
        in_chan.ready = 1'b1;
        if (accept) begin
          id_nxt      = in_id;
          earlier_nxt = dec_earlier;
          status_nxt  = dec_status;
          seen_nxt    = lodc_pkg::lock_vec_t'(1) << in_id;
          stk_cmd.id  = in_id;
          if (!need_search && dec_status == lodc_pkg::ST_OK) begin
            stk_cmd.push = (in_chan.kind == lodc_pkg::KIND_ACQUIRE);
            stk_cmd.pop  = (in_chan.kind == lodc_pkg::KIND_RELEASE);
          end
        end
      end
      lodc_pkg::S_SEARCH: begin
        seen_nxt = reach_nxt;
        if (search_hit) begin
          status_nxt = lodc_pkg::ST_DEADLOCK;
        end else if (search_done) begin
          status_nxt   = lodc_pkg::ST_OK;
          edge_set     = 1'b1;
          stk_cmd.push = 1'b1;
        end
      end
      lodc_pkg::S_EMIT: begin
        out_load = !out_valid_r || out_chan.ready;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lodc_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item and result payload
  always_ff @(posedge clk) begin
    status_r  <= status_nxt;
    id_r      <= id_nxt;
    earlier_r <= earlier_nxt;
    seen_r    <= seen_nxt;
    if (out_load) begin
      out_status_r  <= status_r;
      out_earlier_r <= lodc_pkg::lock_to_port(earlier_r);
      out_count_r   <= lodc_pkg::depth_to_count(stk_depth);
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.status       = out_status_r;
  assign out_chan.earlier_lock = out_earlier_r;
  assign out_chan.held_count   = out_count_r;

  // The stack never grows past its depth
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stk_depth <= lodc_pkg::DEPTH_W'(lodc_pkg::STACK_DEPTH))
    else $error("held stack depth beyond capacity");

  // A walk that reached the earlier lock must not keep going
  a_search_open: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == lodc_pkg::S_SEARCH |-> !seen_r[earlier_r] && seen_r[id_r])
    else $error("graph walk state inconsistent");

  // An accepted item always leaves idle
  a_accept_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != lodc_pkg::S_IDLE)
    else $error("accepted transfer not processed");

  // A new edge goes in only together with the push of its target
  a_edge_push: assert property (@(posedge clk) disable iff (!rst_n)
    edge_set |-> stk_cmd.push && !stk_cmd.pop && !full)
    else $error("edge recorded without push");

  // The stack changes only when an item commits
  a_stack_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == lodc_pkg::S_EMIT |=> $stable(stk_depth))
    else $error("stack moved while result pending");

endmodule
`default_nettype wire
